// ----- rtl/lef_pkg.sv -----
package lef_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned PREFIX_N = 6;
  localparam int unsigned PIDX_W   = 3;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_BODY,
    ST_CR,
    ST_LF
  } state_t;

  // The "Echo: " banner that opens every flush.
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [PIDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h63;
      3'd2:    b = 8'h68;
      3'd3:    b = 8'h6F;
      3'd4:    b = 8'h3A;
      3'd5:    b = 8'h20;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/lef_ram.sv -----
module lef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 50,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/line_echo_framer.sv -----
// Line echo framer. Received bytes are accepted one per transaction and
// appended to a line store; a non-CR byte that does not fill the store is
// absorbed and produces nothing. A carriage return, or the byte that fills
// the store, starts a flush that sends "Echo: ", the stored bytes in order,
// then CR and LF, with out_last_of_run set on the LF. The flush runs out of
// the single read port of the line store, one byte per cycle while the
// output is not stalled. in_stall is high for the whole flush; a new byte is
// taken again as soon as the LF is loaded into the output register.
module line_echo_framer #(
  parameter int unsigned LINE_CAPACITY = 50
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_run
);

  localparam int unsigned AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [lef_pkg::FILL_W-1:0] CAP = lef_pkg::FILL_W'(LINE_CAPACITY);

  lef_pkg::state_t state_r, state_nxt;

  logic [lef_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [lef_pkg::FILL_W-1:0] idx_r, idx_nxt;
  logic [lef_pkg::PIDX_W-1:0] pidx_r, pidx_nxt;

  logic                       out_valid_r;
  logic [lef_pkg::BYTE_W-1:0] out_tx_byte_r;
  logic                       out_last_r;

  logic                       accept;
  logic                       is_cr;
  logic [lef_pkg::FILL_W-1:0] fill_inc;
  logic                       slot_free;
  logic                       load;
  logic [lef_pkg::BYTE_W-1:0] load_byte;
  logic                       load_last;
  logic                       body_last;
  logic [lef_pkg::FILL_W-1:0] rd_idx;
  logic                       wr_en;
  logic [lef_pkg::BYTE_W-1:0] rd_data;

  assign in_stall  = (state_r != lef_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_cr     = (in_rx_byte == lef_pkg::CHAR_CR);
  assign fill_inc  = fill_r + 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign body_last = ((idx_r + 1'b1) == fill_r);
  assign wr_en     = accept && !is_cr;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lef_pkg::ST_IDLE: begin
        if (accept && (is_cr || fill_inc >= CAP)) begin
          state_nxt = lef_pkg::ST_PREFIX;
        end
      end
      lef_pkg::ST_PREFIX: begin
        if (load && pidx_r == lef_pkg::PIDX_W'(lef_pkg::PREFIX_N - 1)) begin
          state_nxt = (fill_r == '0) ? lef_pkg::ST_CR : lef_pkg::ST_BODY;
        end
      end
      lef_pkg::ST_BODY: begin
        if (load && body_last) begin
          state_nxt = lef_pkg::ST_CR;
        end
      end
      lef_pkg::ST_CR: begin
        if (load) begin
          state_nxt = lef_pkg::ST_LF;
        end
      end
      lef_pkg::ST_LF: begin
        if (load) begin
          state_nxt = lef_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lef_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    load      = 1'b0;
    load_byte = lef_pkg::CHAR_LF;
    load_last = 1'b0;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    rd_idx    = '0;
    unique case (state_r)
      lef_pkg::ST_IDLE: begin
        idx_nxt  = '0;
        pidx_nxt = '0;
        if (wr_en) begin
          fill_nxt = fill_inc;
        end
      end
      lef_pkg::ST_PREFIX: begin
        load      = slot_free;
        load_byte = lef_pkg::prefix_byte(pidx_r);
        if (load) begin
          pidx_nxt = pidx_r + 1'b1;
        end
      end
      lef_pkg::ST_BODY: begin
        // The read port always looks at the entry being sent, one ahead once it moves.
        load      = slot_free;
        load_byte = rd_data;
        rd_idx    = idx_r;
        if (load && !body_last) begin
          idx_nxt = idx_r + 1'b1;
          rd_idx  = idx_r + 1'b1;
        end
      end
      lef_pkg::ST_CR: begin
        load      = slot_free;
        load_byte = lef_pkg::CHAR_CR;
      end
      lef_pkg::ST_LF: begin
        load      = slot_free;
        load_byte = lef_pkg::CHAR_LF;
        load_last = 1'b1;
        if (load) begin
          fill_nxt = '0;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lef_pkg::ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      pidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      pidx_r  <= pidx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tx_byte_r <= load_byte;
      out_last_r    <= load_last;
    end
  end

  lef_ram #(
    .WIDTH(lef_pkg::BYTE_W),
    .DEPTH(LINE_CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(in_rx_byte),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_tx_byte     = out_tx_byte_r;
  assign out_last_of_run = out_last_r;

  // A full store never sits idle; it is flushed right away.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lef_pkg::ST_IDLE) |-> (fill_r < CAP))
    else $error("line store left full while idle");

  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lef_pkg::ST_BODY) |-> (fill_r != '0) && (idx_r < fill_r))
    else $error("body read outside stored bytes");

  a_lf_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lef_pkg::ST_LF && load) |=>
      (state_r == lef_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("flush did not end with a marked LF");

endmodule
